[design/bmp_pkg.sv]
package bmp_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int MW          = 30;
   localparam int PW          = 2 * MW;
   localparam int CW          = $clog2(PW + 1);

   localparam logic [MW-1:0] MODULUS_RESET = MW'(998244353);

   localparam logic REQ_BUILD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic          fact_we;
      logic          fact_re;
      logic [AW-1:0] fact_addr;
      logic          inv_we;
      logic          inv_re;
      logic [AW-1:0] inv_addr;
      logic [MW-1:0] wdata;
   } mem_req_type;

endpackage

[design/bmp_mulmod.sv]
module bmp_mulmod
   import bmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] op_a,
   input  logic [MW-1:0] op_b,
   input  logic [MW-1:0] modulus,
   output logic          done,
   output logic [MW-1:0] result
);

   logic [PW-1:0] prod_ff, prod_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [MW:0]   trial;

   // restoring remainder of the product, one product bit a cycle
   always_comb begin
      trial   = {rem_ff, prod_ff[PW-1]};
      prod_in = prod_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = PW'(op_a) * PW'(op_b);
         rem_in  = '0;
         cnt_in  = CW'(PW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         rem_in  = trial[MW-1:0];
         prod_in = {prod_ff[PW-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

[design/bmp_tables.sv]
module bmp_tables
   import bmp_pkg::*;
(
   input  logic          clock,
   input  mem_req_type   mem_req,
   output logic [MW-1:0] fact_rdata,
   output logic [MW-1:0] inv_rdata
);

   logic [MW-1:0] fact_mem [TABLE_DEPTH];
   logic [MW-1:0] inv_mem  [TABLE_DEPTH];
   logic [MW-1:0] fact_rd_ff;
   logic [MW-1:0] inv_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.fact_we) begin
         fact_mem[mem_req.fact_addr] <= mem_req.wdata;
      end
      if (mem_req.fact_re) begin
         fact_rd_ff <= fact_mem[mem_req.fact_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.inv_we) begin
         inv_mem[mem_req.inv_addr] <= mem_req.wdata;
      end
      if (mem_req.inv_re) begin
         inv_rd_ff <= inv_mem[mem_req.inv_addr];
      end
   end

   assign fact_rdata = fact_rd_ff;
   assign inv_rdata  = inv_rd_ff;

endmodule

[design/binomial_mod_prime_engine.sv]
// Binomial coefficient modulo a prime, from factorial tables.
// Requests: start with req_type, req_top, req_bottom; taken when busy is low.
// A build (req_type 0) fills the factorial table, raises the last entry to
// the power modulus-2 and back-fills the inverse table, then returns value 0.
// A query (req_type 1) returns C(top, bottom) mod modulus, or 0 if top < bottom.
// Each request gives one result beat on rsp_value with rsp_valid high for one
// cycle; the receiver cannot stall, so results are never held back.
// Cost is set by the shared modular multiplier: each product is a multiply,
// then 60 remainder steps, one bit a cycle.
// Query: table reads, then two products; top < bottom answers straight from idle.
// Build: (TABLE_DEPTH - 1) * 2 table products plus up to 60 for the power.
// Only one request is in flight; busy stays high until its result beat.
// csr_modulus is written through csr_we/csr_wdata; the user must write it only
// while idle, as the block does not enforce it. Reset (synchronous) returns
// to idle and loads modulus 998244353; table contents are undefined until a build.
module binomial_mod_prime_engine
   import bmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_type,
   input  logic [11:0]   req_top,
   input  logic [11:0]   req_bottom,
   output logic          rsp_valid,
   output logic [MW-1:0] rsp_value,
   input  logic          csr_we,
   input  logic [MW-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_FACT = 9'b000000010,
      ST_POW  = 9'b000000100,
      ST_SQ   = 9'b000001000,
      ST_INV  = 9'b000010000,
      ST_QRD0 = 9'b000100000,
      ST_QRD1 = 9'b001000000,
      ST_QM1  = 9'b010000000,
      ST_QM2  = 9'b100000000
   } state_type;

   localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

   state_type     state_ff, state_in;
   logic [MW-1:0] modulus_ff;
   logic          pend_ff, pend_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [MW-1:0] p_ff, p_in;
   logic [MW-1:0] base_ff, base_in;
   logic [MW-1:0] exp_ff, exp_in;
   logic [MW-1:0] f_ff, f_in;
   logic [MW-1:0] ib_ff, ib_in;
   logic [11:0]   top_ff, top_in;
   logic [11:0]   bot_ff, bot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] rsp_value_ff, rsp_value_in;

   logic [MW-1:0] m_eff, one, exp_init;
   logic          mm_start, mm_done;
   logic [MW-1:0] mm_a, mm_b, mm_res;
   logic [MW-1:0] fact_rdata, inv_rdata;
   logic [11:0]   diff;
   mem_req_type   mem_req;

   assign m_eff    = (modulus_ff == '0) ? MW'(1) : modulus_ff;
   assign one      = (m_eff == MW'(1)) ? '0 : MW'(1);
   assign exp_init = (m_eff >= MW'(2)) ? m_eff - MW'(2) : '0;
   assign diff     = top_ff - bot_ff;

   bmp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (m_eff),
      .done    (mm_done),
      .result  (mm_res)
   );

   bmp_tables u_tables (
      .clock      (clock),
      .mem_req    (mem_req),
      .fact_rdata (fact_rdata),
      .inv_rdata  (inv_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      f_in         = f_ff;
      ib_in        = ib_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      mm_start     = 1'b0;
      mm_a         = '0;
      mm_b         = '0;
      mem_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_BUILD) begin
                  mem_req.fact_we   = 1'b1;
                  mem_req.fact_addr = '0;
                  mem_req.wdata     = one;
                  p_in              = one;
                  idx_in            = AW'(1);
                  state_in          = ST_FACT;
               end else begin
                  top_in = req_top;
                  bot_in = req_bottom;
                  if (req_top < req_bottom || 32'(req_top) >= TABLE_DEPTH) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                  end else begin
                     state_in = ST_QRD0;
                  end
               end
            end
         end
         ST_FACT: begin
            mm_a = p_ff;
            mm_b = MW'(idx_ff);
            if (!pend_ff) begin
               mm_start = 1'b1;
               pend_in  = 1'b1;
            end else if (mm_done) begin
               pend_in           = 1'b0;
               p_in              = mm_res;
               mem_req.fact_we   = 1'b1;
               mem_req.fact_addr = idx_ff;
               mem_req.wdata     = mm_res;
               if (idx_ff == LAST) begin
                  base_in  = mm_res;
                  p_in     = one;
                  exp_in   = exp_init;
                  state_in = ST_POW;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         ST_POW: begin
            mm_a = p_ff;
            mm_b = base_ff;
            if (exp_ff == '0) begin
               mem_req.inv_we   = 1'b1;
               mem_req.inv_addr = LAST;
               mem_req.wdata    = p_ff;
               idx_in           = LAST;
               state_in         = ST_INV;
            end else if (!exp_ff[0]) begin
               state_in = ST_SQ;
            end else if (!pend_ff) begin
               mm_start = 1'b1;
               pend_in  = 1'b1;
            end else if (mm_done) begin
               pend_in  = 1'b0;
               p_in     = mm_res;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            mm_a = base_ff;
            mm_b = base_ff;
            if (!pend_ff) begin
               mm_start = 1'b1;
               pend_in  = 1'b1;
            end else if (mm_done) begin
               pend_in  = 1'b0;
               base_in  = mm_res;
               exp_in   = exp_ff >> 1;
               state_in = ST_POW;
            end
         end
         ST_INV: begin
            mm_a = p_ff;
            mm_b = MW'(idx_ff);
            if (idx_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               state_in     = ST_IDLE;
            end else if (!pend_ff) begin
               mm_start = 1'b1;
               pend_in  = 1'b1;
            end else if (mm_done) begin
               pend_in          = 1'b0;
               p_in             = mm_res;
               mem_req.inv_we   = 1'b1;
               mem_req.inv_addr = idx_ff - AW'(1);
               mem_req.wdata    = mm_res;
               idx_in           = idx_ff - AW'(1);
            end
         end
         ST_QRD0: begin
            mem_req.fact_re   = 1'b1;
            mem_req.fact_addr = AW'(top_ff);
            mem_req.inv_re    = 1'b1;
            mem_req.inv_addr  = AW'(bot_ff);
            state_in          = ST_QRD1;
         end
         ST_QRD1: begin
            f_in             = fact_rdata;
            ib_in            = inv_rdata;
            mem_req.inv_re   = 1'b1;
            mem_req.inv_addr = AW'(diff);
            state_in         = ST_QM1;
         end
         ST_QM1: begin
            mm_a = f_ff;
            mm_b = ib_ff;
            if (!pend_ff) begin
               mm_start = 1'b1;
               pend_in  = 1'b1;
            end else if (mm_done) begin
               pend_in  = 1'b0;
               p_in     = mm_res;
               state_in = ST_QM2;
            end
         end
         ST_QM2: begin
            mm_a = p_ff;
            mm_b = inv_rdata;
            if (!pend_ff) begin
               mm_start = 1'b1;
               pend_in  = 1'b1;
            end else if (mm_done) begin
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_value_in = mm_res;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
      idx_ff       <= idx_in;
      p_ff         <= p_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      f_ff         <= f_in;
      ib_ff        <= ib_in;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[design/bmp_checker.sv]
module bmp_checker
   import bmp_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic          rsp_valid,
   input logic [MW-1:0] rsp_value
);

   // a result beat always carries a known value
   a_value_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_value))
      else $error("result beat with unknown value");

   // a beat either ends a busy spell or answers a request taken at once
   a_beat_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result beat with no request");

   // no beat while a request is still at work
   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind binomial_mod_prime_engine bmp_checker u_bmp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_value (rsp_value)
);

[bench/binomial_mod_prime_engine_test.sv]
module binomial_mod_prime_engine_test;
   import bmp_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic          kind;
      logic [11:0]   top;
      logic [11:0]   bottom;
   } binom_req_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          start;
   logic          busy;
   logic          req_type;
   logic [11:0]   req_top;
   logic [11:0]   req_bottom;
   logic          rsp_valid;
   logic [MW-1:0] rsp_value;
   logic          csr_we;
   logic [MW-1:0] csr_wdata;

   binom_req_type pending_reqs[$];
   logic [MW-1:0] expected_values[$];
   longint        fact_model[TABLE_DEPTH];
   longint        inv_fact_model[TABLE_DEPTH];
   logic [MW-1:0] modulus_model;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            gap_left = 0;
   bit            quiet = 1'b0;
   bit            took;
   binom_req_type beat;

   binomial_mod_prime_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_top(req_top), .req_bottom(req_bottom),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint effective_modulus();
      return (modulus_model == '0) ? 64'd1 : longint'(modulus_model);
   endfunction

   function automatic longint power_mod(longint base, longint expo, longint m);
      longint acc;
      acc  = 1 % m;
      base = base % m;
      while (expo != 0) begin
         if (expo[0]) acc = acc * base % m;
         base = base * base % m;
         expo = expo >> 1;
      end
      return acc;
   endfunction

   function automatic void rebuild_tables();
      longint m;
      m = effective_modulus();
      fact_model[0] = 1 % m;
      for (int i = 1; i < TABLE_DEPTH; i++)
         fact_model[i] = fact_model[i-1] * i % m;
      inv_fact_model[TABLE_DEPTH-1] =
         power_mod(fact_model[TABLE_DEPTH-1], (m >= 2) ? m - 2 : 0, m);
      for (int i = TABLE_DEPTH - 1; i > 0; i--)
         inv_fact_model[i-1] = inv_fact_model[i] * i % m;
   endfunction

   function automatic logic [MW-1:0] binomial_value(binom_req_type r);
      longint m, acc;
      if (r.kind == REQ_BUILD) begin
         rebuild_tables();
         return '0;
      end
      if (r.top < r.bottom) return '0;
      m   = effective_modulus();
      acc = fact_model[r.top] * inv_fact_model[r.bottom] % m;
      acc = acc * inv_fact_model[r.top - r.bottom] % m;
      return MW'(acc);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            beat = pending_reqs.pop_front();
            expected_values = {expected_values, binomial_value(beat)};
            if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 19);
         end else if (!start && gap_left > 0) begin
            gap_left--;
         end
         if (start && !took) begin
            // hold the beat until taken
         end else if (gap_left == 0 && pending_reqs.size() > 0) begin
            start      <= 1'b1;
            req_type   <= pending_reqs[0].kind;
            req_top    <= pending_reqs[0].top;
            req_bottom <= pending_reqs[0].bottom;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [MW-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: value %0d", rsp_value);
         end else begin
            want = expected_values.pop_front();
            if (rsp_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("value mismatch: expected %0d, got %0d", want, rsp_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("binomial_mod_prime_engine_test failed");
         $finish;
      end
   end

   task automatic add_query(int t, int b);
      binom_req_type r;
      r.kind   = REQ_QUERY;
      r.top    = 12'(t);
      r.bottom = 12'(b);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic add_random_queries(int count);
      int t, b;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: begin t = $urandom_range(0, 4095); b = $urandom_range(0, 4095); end
            1, 2: begin t = $urandom_range(0, 31); b = $urandom_range(0, t); end
            3: begin t = $urandom_range(4000, 4095); b = $urandom_range(0, t); end
            default: begin t = $urandom_range(0, 4095); b = $urandom_range(0, t); end
         endcase
         add_query(t, b);
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_values.size() > 0 || start || busy)
         @(negedge clock);
   endtask

   task automatic write_modulus(logic [MW-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      modulus_model = v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      binom_req_type r;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_type   <= REQ_BUILD;
      req_top    <= '0;
      req_bottom <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      modulus_model = MODULUS_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fact_model[i]     = 0;
         inv_fact_model[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // tables under the reset modulus
      r.kind = REQ_BUILD; r.top = 12'hfff; r.bottom = 12'h0;
      pending_reqs = {pending_reqs, r};
      add_query(0, 0);      add_query(4095, 4095); add_query(4095, 0);
      add_query(4095, 2048); add_query(4095, 4094); add_query(0, 1);
      add_query(0, 4095);   add_query(4094, 4095); add_query(1, 0);
      add_query(10, 3);     add_query(2730, 1365); add_query(1365, 2730);
      add_query(4095, 1);   add_query(2048, 1024);
      add_random_queries(400);
      drain();

      write_modulus(30'h3fffffff);
      add_query(4095, 2048); add_query(3, 5);
      add_random_queries(300);
      drain();

      write_modulus(30'd2);
      add_random_queries(200);
      drain();

      write_modulus(30'd0);
      add_query(4095, 17);
      add_random_queries(150);
      drain();

      write_modulus(30'd4099);
      add_random_queries(300);
      drain();

      write_modulus(MW'($urandom_range(2, 30'h3fffffff)));
      add_random_queries(300);
      drain();

      write_modulus(MODULUS_RESET);
      quiet = 1'b1;
      gap_left = 0;
      add_random_queries(280);
      drain();

      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_values.size() == 0) begin
         $display("binomial_mod_prime_engine_test passed");
      end else begin
         $display("binomial_mod_prime_engine_test failed");
      end
      $finish;
   end

endmodule

[sim.f]
design/bmp_pkg.sv
design/bmp_mulmod.sv
design/bmp_tables.sv
design/binomial_mod_prime_engine.sv
design/bmp_checker.sv
bench/binomial_mod_prime_engine_test.sv
